>>> design/lfac_pkg.sv
// Shared types and constants for the fully associative LRU cache.
// Used by the controller, the datapath and the top level; no dependencies.
package lfac_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_BITS  = 32;
  localparam int DATA_BITS = 32;
  localparam int KIND_BITS = 2;
  localparam int CAP_BITS  = 5;
  localparam int IDX_BITS  = $clog2(ENTRIES);
  localparam int RANK_BITS = IDX_BITS;
  localparam int CNT_BITS  = $clog2(ENTRIES + 1);
  localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic apply;
  } cmd_t;

endpackage

>>> design/lfac_ctrl.sv
// Controller for the LRU cache: sequences accept, lookup and update of an item
// and owns the output valid flag. Depends on lfac_pkg.
module lfac_ctrl import lfac_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = (state != ST_IDLE);
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        // The update waits until the output register is free for its result.
        if (!out_valid || !out_stall) begin
          cmd.apply      = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> design/lfac_datapath.sv
// Datapath for the LRU cache: entry storage, parallel key compare, recency
// ranks, occupancy count, capacity register and output registers. Depends on lfac_pkg.
module lfac_datapath import lfac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic                 cfg_we,
  input  logic [CAP_BITS-1:0]  cfg_data,
  input  logic [KIND_BITS-1:0] kind,
  input  logic [KEY_BITS-1:0]  address,
  input  logic [DATA_BITS-1:0] write_data,
  output logic                 hit,
  output logic [DATA_BITS-1:0] read_data,
  output logic [CNT_BITS-1:0]  occupancy
);

  logic [CAP_BITS-1:0]  capacity;
  logic [ENTRIES-1:0]   valid;
  logic [RANK_BITS-1:0] rank [ENTRIES];
  logic [KEY_BITS-1:0]  key_mem [ENTRIES];
  logic [DATA_BITS-1:0] value_mem [ENTRIES];
  logic [CNT_BITS-1:0]  occ;

  logic [KIND_BITS-1:0] req_kind;
  logic [KEY_BITS-1:0]  req_addr;
  logic [DATA_BITS-1:0] req_data;

  logic                 l_found;
  logic [IDX_BITS-1:0]  l_idx;
  logic [RANK_BITS-1:0] l_rank;
  logic [DATA_BITS-1:0] l_data;

  logic [ENTRIES-1:0]   match;
  logic [IDX_BITS-1:0]  found_idx;

  logic [CMP_BITS-1:0]  cap_lim;
  logic [CMP_BITS-1:0]  cap_m1;
  logic [CMP_BITS-1:0]  occ_ext;
  logic [ENTRIES-1:0]   kept;
  logic                 slot_free;
  logic [IDX_BITS-1:0]  slot;
  logic [ENTRIES-1:0]   valid_next;
  logic [RANK_BITS-1:0] rank_next [ENTRIES];
  logic [CNT_BITS-1:0]  occ_next;
  logic                 key_we;
  logic                 value_we;
  logic [IDX_BITS-1:0]  wr_idx;
  logic [DATA_BITS-1:0] rd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= kind;
      req_addr <= address;
      req_data <= write_data;
    end
  end

  // Lowest-numbered matching slot wins, though at most one can match.
  always_comb begin
    found_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid[i] && (key_mem[i] == req_addr);
      if (match[i]) found_idx = IDX_BITS'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      l_found <= |match;
      l_idx   <= found_idx;
      l_rank  <= rank[found_idx];
      l_data  <= value_mem[found_idx];
    end
  end

  always_comb begin
    cap_lim = CMP_BITS'(capacity);
    if (cap_lim == '0) cap_lim = CMP_BITS'(1);
    else if (cap_lim > CMP_BITS'(ENTRIES)) cap_lim = CMP_BITS'(ENTRIES);
    cap_m1  = cap_lim - CMP_BITS'(1);
    occ_ext = CMP_BITS'(occ);
  end

  always_comb begin
    valid_next = valid;
    rank_next  = rank;
    occ_next   = occ;
    key_we     = 1'b0;
    value_we   = 1'b0;
    wr_idx     = l_idx;
    rd_next    = '0;
    kept       = '0;
    slot_free  = 1'b0;
    slot       = '0;
    case (req_kind)
      KIND_READ: begin
        if (l_found) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid[i] && rank[i] < l_rank) rank_next[i] = rank[i] + RANK_BITS'(1);
          end
          rank_next[l_idx] = '0;
          rd_next          = l_data;
        end
      end
      KIND_WRITE: begin
        if (l_found) begin
          value_we = 1'b1;
        end else begin
          // Entries whose rank reaches capacity - 1 go, leaving room for one.
          for (int i = ENTRIES - 1; i >= 0; i--) begin
            kept[i] = valid[i] && (CMP_BITS'(rank[i]) < cap_m1);
            if (kept[i]) begin
              rank_next[i] = rank[i] + RANK_BITS'(1);
            end else begin
              slot_free = 1'b1;
              slot      = IDX_BITS'(i);
            end
          end
          valid_next = kept;
          // The valid ranks are distinct and dense, so the kept count is a minimum.
          occ_next = CNT_BITS'((occ_ext < cap_m1) ? occ_ext : cap_m1);
          if (slot_free) begin
            valid_next[slot] = 1'b1;
            rank_next[slot]  = '0;
            key_we           = 1'b1;
            value_we         = 1'b1;
            wr_idx           = slot;
            occ_next         = occ_next + CNT_BITS'(1);
          end
        end
      end
      KIND_REMOVE: begin
        if (l_found) begin
          valid_next[l_idx] = 1'b0;
          rank_next[l_idx]  = '0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_next[i] && rank[i] > l_rank) rank_next[i] = rank[i] - RANK_BITS'(1);
          end
          occ_next = occ - CNT_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
      for (int i = 0; i < ENTRIES; i++) rank[i] <= '0;
    end else if (cmd.apply) begin
      valid <= valid_next;
      occ   <= occ_next;
      rank  <= rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && key_we) key_mem[wr_idx] <= req_addr;
    if (cmd.apply && value_we) value_mem[wr_idx] <= req_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      hit       <= l_found;
      read_data <= rd_next;
      occupancy <= occ_next;
    end
  end

endmodule

>>> design/lru_fully_associative_cache_unit.sv
// Fully associative cache of sixteen entries with least-recently-used
// replacement; each item reads, writes (insert or update) or removes one
// entry and yields one result with hit, read data and occupancy. An item
// passes through accept, which loads it into the request register, lookup,
// which compares its address against all stored keys into the lookup
// register, and update of ranks, storage and the output register; a new item
// is taken only once the update is done. The update waits while a previous
// result is still stalled in the output register. The capacity
// register may be written at any time the block is idle and is always ready.
// Depends on lfac_pkg, lfac_ctrl and lfac_datapath.
module lru_fully_associative_cache_unit import lfac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KIND_BITS-1:0] kind,
  input  logic [KEY_BITS-1:0]  address,
  input  logic [DATA_BITS-1:0] write_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic [DATA_BITS-1:0] read_data,
  output logic [CNT_BITS-1:0]  occupancy,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CAP_BITS-1:0]  cfg_data
);

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  lfac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lfac_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .address    (address),
    .write_data (write_data),
    .hit        (hit),
    .read_data  (read_data),
    .occupancy  (occupancy)
  );

  // After an item is taken the block stays busy until its update is done.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous item still in flight");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occupancy <= CNT_BITS'(ENTRIES)))
    else $error("occupancy exceeds entry count");

  a_miss_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (read_data == '0))
    else $error("read data nonzero on a miss");

endmodule
